// ===== sv/podu_pkg.sv =====
package podu_pkg;

   localparam int unsigned MAX_HAPLOTYPES_DEF = 64;
   localparam int unsigned SITE_BITS_DEF      = 32;
   localparam int unsigned ALLELE_W           = 64;
   localparam int unsigned COUNT_W            = 7;
   localparam int unsigned ID_W               = 6;
   localparam int unsigned DIV_OUT_W          = 32;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;

   typedef struct packed {
      logic                valid;
      logic [ALLELE_W-1:0] alleles;
   } queue_word_type;

endpackage

// ===== sv/podu_front.sv =====
module podu_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [podu_pkg::ALLELE_W-1:0] req_site_alleles,
   input  logic                       pop,
   output podu_pkg::queue_word_type   head
);
   import podu_pkg::*;

   logic [ALLELE_W-1:0] slot_ff [2];
   logic [1:0]          fill_ff, fill_in;
   logic                rd_ptr_ff, wr_ptr_ff;
   logic                push, take;

   assign req_stall    = (fill_ff == 2'd2);
   assign push         = req_valid && !req_stall;
   assign take         = pop && (fill_ff != 2'd0);
   assign head.valid   = (fill_ff != 2'd0);
   assign head.alleles = slot_ff[rd_ptr_ff];

   always_comb begin
      fill_in = fill_ff;
      if (push && !take) begin
         fill_in = fill_ff + 2'd1;
      end else if (take && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= 2'd0;
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (take) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= req_site_alleles;
      end
   end

endmodule

// ===== sv/podu_back.sv =====
module podu_back #(
   parameter int unsigned MAX_HAPLOTYPES = podu_pkg::MAX_HAPLOTYPES_DEF,
   parameter int unsigned SITE_BITS      = podu_pkg::SITE_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [podu_pkg::COUNT_W-1:0]   csr_wr_data,
   input  podu_pkg::queue_word_type       head,
   output logic                           pop,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [podu_pkg::ID_W-1:0]      rsp_haplotype_id,
   output logic [podu_pkg::DIV_OUT_W-1:0] rsp_divergence,
   output logic                           rsp_last_of_site
);
   import podu_pkg::*;

   localparam int unsigned HID_W = $clog2(MAX_HAPLOTYPES);
   localparam int unsigned CNT_W = $clog2(MAX_HAPLOTYPES + 1);
   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_HAPLOTYPES);

   typedef enum logic [1:0] {IDLE, WALK, READ, EMIT} state_type;

   state_type             state_ff;
   logic [COUNT_W-1:0]    count_ff;
   logic [SITE_BITS-1:0]  site_ff;
   logic [ALLELE_W-1:0]   alleles_ff;
   logic [CNT_W-1:0]      i_ff, u_ff, v_ff, j_ff;
   logic [SITE_BITS-1:0]  p_ff, q_ff;
   logic                  rd_pend_ff;
   logic [HID_W-1:0]      rd_idx_ff;
   logic [HID_W-1:0]      cur_id_mem  [MAX_HAPLOTYPES];
   logic [SITE_BITS-1:0]  cur_div_mem [MAX_HAPLOTYPES];
   logic [MAX_HAPLOTYPES-1:0] cur_ok_ff;
   logic [HID_W-1:0]      zero_id_mem  [MAX_HAPLOTYPES];
   logic [SITE_BITS-1:0]  zero_div_mem [MAX_HAPLOTYPES];
   logic [HID_W-1:0]      one_id_mem   [MAX_HAPLOTYPES];
   logic [SITE_BITS-1:0]  one_div_mem  [MAX_HAPLOTYPES];
   logic [HID_W-1:0]      rd_id_ff, z_id_ff, o_id_ff;
   logic [SITE_BITS-1:0]  rd_div_ff, z_div_ff, o_div_ff;
   logic                  rd_ok_ff, sel_one_ff;
   logic                  rsp_valid_ff;
   logic [ID_W-1:0]       rsp_id_ff;
   logic [DIV_OUT_W-1:0]  rsp_div_ff;
   logic                  rsp_last_ff;

   logic [COUNT_W-1:0]    n_full;
   logic [CNT_W-1:0]      n;
   logic [SITE_BITS-1:0]  seed;
   logic [HID_W-1:0]      w_id, e_id;
   logic [SITE_BITS-1:0]  w_div, pm, qm, e_div;
   logic [CNT_W-1:0]      one_pos;
   logic                  out_free, last;

   always_comb begin
      if (count_ff == '0) begin
         n_full = COUNT_W'(1);
      end else if (count_ff > MAX_COUNT) begin
         n_full = MAX_COUNT;
      end else begin
         n_full = count_ff;
      end
      n       = CNT_W'(n_full);
      seed    = (&site_ff) ? site_ff : site_ff + 1'b1;
      w_id    = rd_ok_ff ? rd_id_ff  : rd_idx_ff;
      w_div   = rd_ok_ff ? rd_div_ff : '0;
      pm      = (w_div > p_ff) ? w_div : p_ff;
      qm      = (w_div > q_ff) ? w_div : q_ff;
      one_pos = j_ff - u_ff;
      e_id    = sel_one_ff ? o_id_ff  : z_id_ff;
      e_div   = sel_one_ff ? o_div_ff : z_div_ff;
      out_free = !rsp_valid_ff || !rsp_stall;
      last    = (j_ff == n - 1'b1);
   end

   assign pop              = (state_ff == IDLE) && head.valid;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_haplotype_id = rsp_id_ff;
   assign rsp_divergence   = rsp_div_ff;
   assign rsp_last_of_site = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         count_ff     <= COUNT_RESET;
         site_ff      <= '0;
         cur_ok_ff    <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && (state_ff != EMIT)) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            count_ff  <= csr_wr_data;
            site_ff   <= '0;
            cur_ok_ff <= '0;
         end
         unique case (state_ff)
            IDLE: begin
               if (head.valid) begin
                  alleles_ff <= head.alleles;
                  i_ff       <= '0;
                  u_ff       <= '0;
                  v_ff       <= '0;
                  p_ff       <= seed;
                  q_ff       <= seed;
                  rd_pend_ff <= 1'b0;
                  state_ff   <= WALK;
               end
            end
            WALK: begin
               rd_pend_ff <= (i_ff < n);
               if (i_ff < n) begin
                  rd_id_ff  <= cur_id_mem[i_ff[HID_W-1:0]];
                  rd_div_ff <= cur_div_mem[i_ff[HID_W-1:0]];
                  rd_ok_ff  <= cur_ok_ff[i_ff[HID_W-1:0]];
                  rd_idx_ff <= i_ff[HID_W-1:0];
                  i_ff      <= i_ff + 1'b1;
               end
               if (rd_pend_ff) begin
                  if (!alleles_ff[w_id]) begin
                     zero_id_mem[u_ff[HID_W-1:0]]  <= w_id;
                     zero_div_mem[u_ff[HID_W-1:0]] <= pm;
                     u_ff <= u_ff + 1'b1;
                     p_ff <= '0;
                     q_ff <= qm;
                  end else begin
                     one_id_mem[v_ff[HID_W-1:0]]  <= w_id;
                     one_div_mem[v_ff[HID_W-1:0]] <= qm;
                     v_ff <= v_ff + 1'b1;
                     q_ff <= '0;
                     p_ff <= pm;
                  end
               end else if (i_ff == n) begin
                  j_ff     <= '0;
                  state_ff <= READ;
               end
            end
            READ: begin
               z_id_ff    <= zero_id_mem[j_ff[HID_W-1:0]];
               z_div_ff   <= zero_div_mem[j_ff[HID_W-1:0]];
               o_id_ff    <= one_id_mem[one_pos[HID_W-1:0]];
               o_div_ff   <= one_div_mem[one_pos[HID_W-1:0]];
               sel_one_ff <= (j_ff >= u_ff);
               state_ff   <= EMIT;
            end
            EMIT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_id_ff    <= ID_W'(e_id);
                  rsp_div_ff   <= DIV_OUT_W'(e_div);
                  rsp_last_ff  <= last;
                  cur_id_mem[j_ff[HID_W-1:0]]  <= e_id;
                  cur_div_mem[j_ff[HID_W-1:0]] <= e_div;
                  cur_ok_ff[j_ff[HID_W-1:0]]   <= 1'b1;
                  j_ff <= j_ff + 1'b1;
                  if (last) begin
                     if (!(&site_ff)) begin
                        site_ff <= site_ff + 1'b1;
                     end
                     state_ff <= IDLE;
                  end else begin
                     state_ff <= READ;
                  end
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

endmodule

// ===== sv/pbwt_order_divergence_update_unit.sv =====
// channel   direction  ports
// req_      in         req_valid, req_stall, req_site_alleles (one site word)
// rsp_      out        rsp_valid, rsp_stall, rsp_haplotype_id, rsp_divergence,
//                      rsp_last_of_site (one word per active haplotype)
// csr_      in         csr_wr_en, csr_wr_data (haplotype count, restarts order)
//
// For n active haplotypes a site is taken from the queue, then the order memory
// is walked once, then each output word is read through the split memories.
// A two-word queue takes sites while the previous one is still being walked.
// Reset restores the identity order, zero divergence and a count of 64 at once.
// rsp_stall holds the output word and pauses the write-back of the new order.
module pbwt_order_divergence_update_unit #(
   parameter int unsigned MAX_HAPLOTYPES = podu_pkg::MAX_HAPLOTYPES_DEF,
   parameter int unsigned SITE_BITS      = podu_pkg::SITE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [podu_pkg::ALLELE_W-1:0]     req_site_alleles,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [podu_pkg::ID_W-1:0]         rsp_haplotype_id,
   output logic [podu_pkg::DIV_OUT_W-1:0]    rsp_divergence,
   output logic                              rsp_last_of_site,
   input  logic                              csr_wr_en,
   input  logic [podu_pkg::COUNT_W-1:0]      csr_wr_data
);
   import podu_pkg::*;

   queue_word_type head;
   logic           pop;

   podu_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_site_alleles (req_site_alleles),
      .pop              (pop),
      .head             (head)
   );

   podu_back #(
      .MAX_HAPLOTYPES (MAX_HAPLOTYPES),
      .SITE_BITS      (SITE_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .head             (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_haplotype_id (rsp_haplotype_id),
      .rsp_divergence   (rsp_divergence),
      .rsp_last_of_site (rsp_last_of_site)
   );

endmodule
